// ===== rtl/ppm_p6_stream_decoder_top_assert.svh =====
// Assertion macros shared by the decoder's modules.
// With SYNTH defined the macros expand to nothing.
`ifndef PPM_P6_STREAM_DECODER_TOP_ASSERT_SVH
`define PPM_P6_STREAM_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH

// When cond holds at an edge, prop must hold at the same edge.
`define PPMP6_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// When cond holds at an edge, prop must hold at the next edge.
`define PPMP6_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define PPMP6_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define PPMP6_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/ppmp6_pkg.sv =====
package ppmp6_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    // Fixed widths of the result fields.
    localparam int ACC_W    = 17;
    localparam int ADDR_W   = 26;
    localparam int IMG_W    = 13;
    localparam int STRIDE_W = 14;

    // Characters the header parser looks for.
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_SUBTYPE = 4'd1,
        PH_SKIP    = 4'd2,
        PH_DIGITS  = 4'd3,
        PH_PIXELS  = 4'd4,
        PH_DONE    = 4'd5,
        PH_ERROR   = 4'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NO_MAGIC    = 3'd0,
        ERR_UNSUPPORTED = 3'd1,
        ERR_BAD_VALUE   = 3'd2,
        ERR_TOO_LARGE   = 3'd3,
        ERR_TRUNCATED   = 3'd4
    } t_err;

    typedef struct packed {
        t_kind                 kind;
        logic [ADDR_W-1:0]     address;
        logic [7:0]            pixel_byte;
        logic [IMG_W-1:0]      image_width;
        logic [IMG_W-1:0]      image_height;
        logic [STRIDE_W-1:0]   row_stride;
        t_err                  error_code;
        logic                  image_done;
    } t_result;

endpackage

// ===== rtl/ppmp6_core.sv =====
`include "ppm_p6_stream_decoder_top_assert.svh"

module ppmp6_core #(
    parameter int MAX_WIDTH  = ppmp6_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = ppmp6_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_input,
    output logic                o_has_result,
    output ppmp6_pkg::t_result  o_result
);

    localparam int W_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS  = $clog2(MAX_HEIGHT + 1);
    localparam int S_BITS  = $clog2(3 * MAX_WIDTH + 4);
    localparam int PROD_W  = H_BITS + S_BITS;
    localparam int ACC_W   = ppmp6_pkg::ACC_W;
    localparam int ADDR_W  = ppmp6_pkg::ADDR_W;

    localparam logic [ACC_W-1:0] W_LIMIT = ACC_W'(MAX_WIDTH);
    localparam logic [ACC_W-1:0] H_LIMIT = ACC_W'(MAX_HEIGHT);

    localparam logic [1:0] FIELD_WIDTH  = 2'd0;
    localparam logic [1:0] FIELD_HEIGHT = 2'd1;

    ppmp6_pkg::t_phase   r_phase, n_phase;
    logic [1:0]          r_field, n_field;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic                r_ovf, n_ovf;
    logic                r_in_comment, n_in_comment;
    logic [W_BITS-1:0]   r_width, n_width;
    logic [H_BITS-1:0]   r_height, n_height;
    logic [S_BITS-1:0]   r_stride, n_stride;
    logic [ADDR_W-1:0]   r_row_base, n_row_base;
    logic [W_BITS-1:0]   r_col, n_col;
    logic [1:0]          r_comp, n_comp;
    logic [H_BITS-1:0]   r_row_count, n_row_count;

    logic                is_digit;
    logic                is_blank;
    logic [7:0]          digit_off;
    logic [ACC_W+3:0]    acc_next;
    logic [S_BITS-1:0]   stride_sum;
    logic [PROD_W-1:0]   base_prod;
    logic [W_BITS+1:0]   col_x3;
    logic [1:0]          comp_off;
    logic [ADDR_W-1:0]   pix_addr;
    logic [W_BITS-1:0]   col_inc;
    logic [H_BITS-1:0]   row_inc;
    logic [ACC_W-1:0]    field_limit;

    function automatic ppmp6_pkg::t_result error_result(input ppmp6_pkg::t_err code);
        ppmp6_pkg::t_result res;
        res            = '0;
        res.kind       = ppmp6_pkg::KIND_ERROR;
        res.error_code = code;
        return res;
    endfunction

    always_comb begin
        is_digit   = (i_data_byte >= ppmp6_pkg::CH_0) && (i_data_byte <= ppmp6_pkg::CH_9);
        is_blank   = (i_data_byte == ppmp6_pkg::CH_SPACE) || (i_data_byte == ppmp6_pkg::CH_TAB)
                  || (i_data_byte == ppmp6_pkg::CH_LF) || (i_data_byte == ppmp6_pkg::CH_CR);
        digit_off  = i_data_byte - ppmp6_pkg::CH_0;
        acc_next   = ({r_acc, 3'b000} + {2'b00, r_acc, 1'b0}) + (ACC_W+4)'(digit_off[3:0]);
        stride_sum = ((S_BITS'(r_acc[W_BITS-1:0]) << 1) + S_BITS'(r_acc[W_BITS-1:0]))
                   + S_BITS'(3);
        base_prod  = PROD_W'(r_height - H_BITS'(1)) * PROD_W'(r_stride);
        col_x3     = ({2'b00, r_col} << 1) + {2'b00, r_col};
        comp_off   = 2'd2 - r_comp;
        pix_addr   = r_row_base + ADDR_W'(col_x3) + ADDR_W'(comp_off);
        col_inc    = r_col + W_BITS'(1);
        row_inc    = r_row_count + H_BITS'(1);
        field_limit = (r_field == FIELD_WIDTH) ? W_LIMIT : H_LIMIT;
    end

    always_comb begin
        n_phase      = r_phase;
        n_field      = r_field;
        n_acc        = r_acc;
        n_ovf        = r_ovf;
        n_in_comment = r_in_comment;
        n_width      = r_width;
        n_height     = r_height;
        n_stride     = r_stride;
        n_row_base   = r_row_base;
        n_col        = r_col;
        n_comp       = r_comp;
        n_row_count  = r_row_count;
        o_has_result = 1'b0;
        o_result     = '0;

        if (i_accept) begin
            if (i_end_of_input) begin
                // End of input always brings the parser back to its reset state.
                n_phase      = ppmp6_pkg::PH_MAGIC;
                n_field      = '0;
                n_acc        = '0;
                n_ovf        = 1'b0;
                n_in_comment = 1'b0;
                n_width      = '0;
                n_height     = '0;
                n_stride     = '0;
                n_row_base   = '0;
                n_col        = '0;
                n_comp       = '0;
                n_row_count  = '0;
                if (r_phase == ppmp6_pkg::PH_MAGIC) begin
                    o_has_result = 1'b1;
                    o_result     = error_result(ppmp6_pkg::ERR_NO_MAGIC);
                end else if (r_phase != ppmp6_pkg::PH_DONE && r_phase != ppmp6_pkg::PH_ERROR) begin
                    o_has_result = 1'b1;
                    o_result     = error_result(ppmp6_pkg::ERR_TRUNCATED);
                end
            end else begin
                unique case (r_phase)
                    ppmp6_pkg::PH_MAGIC: begin
                        if (i_data_byte != ppmp6_pkg::CH_P) begin
                            o_has_result = 1'b1;
                            o_result     = error_result(ppmp6_pkg::ERR_NO_MAGIC);
                            n_phase      = ppmp6_pkg::PH_ERROR;
                        end else begin
                            n_phase = ppmp6_pkg::PH_SUBTYPE;
                        end
                    end
                    ppmp6_pkg::PH_SUBTYPE: begin
                        if (i_data_byte == ppmp6_pkg::CH_2 || i_data_byte == ppmp6_pkg::CH_3
                            || i_data_byte == ppmp6_pkg::CH_5) begin
                            o_has_result = 1'b1;
                            o_result     = error_result(ppmp6_pkg::ERR_UNSUPPORTED);
                            n_phase      = ppmp6_pkg::PH_ERROR;
                        end else if (i_data_byte != ppmp6_pkg::CH_6) begin
                            o_has_result = 1'b1;
                            o_result     = error_result(ppmp6_pkg::ERR_NO_MAGIC);
                            n_phase      = ppmp6_pkg::PH_ERROR;
                        end else begin
                            n_field      = FIELD_WIDTH;
                            n_in_comment = 1'b0;
                            n_phase      = ppmp6_pkg::PH_SKIP;
                        end
                    end
                    ppmp6_pkg::PH_SKIP: begin
                        if (r_in_comment) begin
                            if (i_data_byte == ppmp6_pkg::CH_LF) begin
                                n_in_comment = 1'b0;
                            end
                        end else if (is_blank) begin
                            n_phase = ppmp6_pkg::PH_SKIP;
                        end else if (i_data_byte == ppmp6_pkg::CH_HASH) begin
                            n_in_comment = 1'b1;
                        end else if (!is_digit) begin
                            o_has_result = 1'b1;
                            o_result     = error_result(ppmp6_pkg::ERR_BAD_VALUE);
                            n_phase      = ppmp6_pkg::PH_ERROR;
                        end else begin
                            n_acc   = ACC_W'(digit_off[3:0]);
                            n_ovf   = 1'b0;
                            n_phase = ppmp6_pkg::PH_DIGITS;
                        end
                    end
                    ppmp6_pkg::PH_DIGITS: begin
                        if (is_digit) begin
                            if (acc_next[ACC_W+3:ACC_W] != '0) begin
                                n_ovf = 1'b1;
                            end
                            n_acc = acc_next[ACC_W-1:0];
                        end else begin
                            // The terminator byte; a '#' here also opens a comment.
                            if (i_data_byte == ppmp6_pkg::CH_HASH) begin
                                n_in_comment = 1'b1;
                            end
                            if (r_field == FIELD_WIDTH || r_field == FIELD_HEIGHT) begin
                                if (!r_ovf && r_acc == '0) begin
                                    o_has_result = 1'b1;
                                    o_result     = error_result(ppmp6_pkg::ERR_BAD_VALUE);
                                    n_phase      = ppmp6_pkg::PH_ERROR;
                                end else if (r_ovf || r_acc > field_limit) begin
                                    o_has_result = 1'b1;
                                    o_result     = error_result(ppmp6_pkg::ERR_TOO_LARGE);
                                    n_phase      = ppmp6_pkg::PH_ERROR;
                                end else begin
                                    if (r_field == FIELD_WIDTH) begin
                                        n_width  = r_acc[W_BITS-1:0];
                                        n_stride = {stride_sum[S_BITS-1:2], 2'b00};
                                    end else begin
                                        n_height = r_acc[H_BITS-1:0];
                                    end
                                    n_field = r_field + 2'd1;
                                    n_phase = ppmp6_pkg::PH_SKIP;
                                end
                            end else begin
                                if (r_acc[15:0] == 16'd0) begin
                                    o_has_result = 1'b1;
                                    o_result     = error_result(ppmp6_pkg::ERR_BAD_VALUE);
                                    n_phase      = ppmp6_pkg::PH_ERROR;
                                end else begin
                                    n_row_base            = ADDR_W'(base_prod);
                                    n_col                 = '0;
                                    n_comp                = '0;
                                    n_row_count           = '0;
                                    n_phase               = ppmp6_pkg::PH_PIXELS;
                                    o_has_result          = 1'b1;
                                    o_result.kind         = ppmp6_pkg::KIND_HEADER;
                                    o_result.image_width  = ppmp6_pkg::IMG_W'(r_width);
                                    o_result.image_height = ppmp6_pkg::IMG_W'(r_height);
                                    o_result.row_stride   = ppmp6_pkg::STRIDE_W'(r_stride);
                                end
                            end
                        end
                    end
                    ppmp6_pkg::PH_PIXELS: begin
                        if (r_in_comment) begin
                            if (i_data_byte == ppmp6_pkg::CH_LF) begin
                                n_in_comment = 1'b0;
                            end
                        end else begin
                            o_has_result        = 1'b1;
                            o_result.kind       = ppmp6_pkg::KIND_PIXEL;
                            o_result.address    = pix_addr;
                            o_result.pixel_byte = i_data_byte;
                            if (r_comp < 2'd2) begin
                                n_comp = r_comp + 2'd1;
                            end else begin
                                n_comp = '0;
                                n_col  = col_inc;
                                if (col_inc >= r_width) begin
                                    n_col       = '0;
                                    n_row_count = row_inc;
                                    n_row_base  = r_row_base - ADDR_W'(r_stride);
                                    if (row_inc >= r_height) begin
                                        n_phase             = ppmp6_pkg::PH_DONE;
                                        o_result.image_done = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ppmp6_pkg::PH_MAGIC;
            r_field      <= '0;
            r_acc        <= '0;
            r_ovf        <= 1'b0;
            r_in_comment <= 1'b0;
            r_width      <= '0;
            r_height     <= '0;
            r_stride     <= '0;
            r_row_base   <= '0;
            r_col        <= '0;
            r_comp       <= '0;
            r_row_count  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_field      <= n_field;
            r_acc        <= n_acc;
            r_ovf        <= n_ovf;
            r_in_comment <= n_in_comment;
            r_width      <= n_width;
            r_height     <= n_height;
            r_stride     <= n_stride;
            r_row_base   <= n_row_base;
            r_col        <= n_col;
            r_comp       <= n_comp;
            r_row_count  <= n_row_count;
        end
    end

    `PPMP6_ASSERT_IMPLY(a_pixel_dims, i_clk, i_rst_n, r_phase == ppmp6_pkg::PH_PIXELS, r_width != '0 && r_height != '0)
    `PPMP6_ASSERT_IMPLY(a_pixel_pos, i_clk, i_rst_n, r_phase == ppmp6_pkg::PH_PIXELS, r_col < r_width && r_row_count < r_height)
    `PPMP6_ASSERT_IMPLY(a_comp_range, i_clk, i_rst_n, 1'b1, r_comp != 2'd3)

endmodule

// ===== rtl/ppmp6_out_buf.sv =====
`include "ppm_p6_stream_decoder_top_assert.svh"

module ppmp6_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ppmp6_pkg::t_result  i_result,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ppmp6_pkg::t_result  o_result
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    ppmp6_pkg::t_result r_out, n_out;
    ppmp6_pkg::t_result r_skid, n_skid;
    logic               pop;

    always_comb begin
        pop          = r_out_valid && !i_out_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `PPMP6_ASSERT_IMPLY(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `PPMP6_ASSERT_NEXT(a_push_to_skid, i_clk, i_rst_n, i_push && r_out_valid && i_out_stall && !r_skid_valid, r_skid_valid)
    `PPMP6_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n, pop && !r_skid_valid && !i_push, !r_out_valid)

endmodule

// ===== rtl/ppm_p6_stream_decoder_top.sv =====
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall | i_data_byte, i_end_of_input
// output  | out       | o_out_valid / i_out_stall | o_kind, o_address, o_pixel_byte,
//         |           |                         | o_image_width, o_image_height,
//         |           |                         | o_row_stride, o_error_code, o_image_done
//
// One input transaction is taken every cycle while o_in_stall is low; the parser
// state and result are computed in one pass, and the result is registered before output.
// Throughput is set by the two-entry result buffer: o_in_stall rises only while
// both entries hold results that the consumer has not yet taken.
// Reset is synchronous and active low; it clears the parser and empties the buffer.
// A stalled output blocks the input only once both entries are full; from then on
// even bytes that would produce no result wait until an entry frees up.

module ppm_p6_stream_decoder_top #(
    parameter int MAX_WIDTH  = ppmp6_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = ppmp6_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_end_of_input,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_kind,
    output logic [ppmp6_pkg::ADDR_W-1:0]      o_address,
    output logic [7:0]                        o_pixel_byte,
    output logic [ppmp6_pkg::IMG_W-1:0]       o_image_width,
    output logic [ppmp6_pkg::IMG_W-1:0]       o_image_height,
    output logic [ppmp6_pkg::STRIDE_W-1:0]    o_row_stride,
    output logic [2:0]                        o_error_code,
    output logic                              o_image_done
);

    // An input transaction completes when valid is high and the buffer has room.
    logic               in_accept;
    logic               buf_full;
    logic               has_result;
    ppmp6_pkg::t_result core_result;
    ppmp6_pkg::t_result out_result;

    assign in_accept  = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    // Header parser and bitmap address generator. It sees each accepted byte once
    // and produces at most one result for it in the same cycle.
    ppmp6_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_has_result   (has_result),
        .o_result       (core_result)
    );

    // Result register with a skid entry behind it, so that the input side keeps
    // flowing while the consumer stalls, until the skid entry is full.
    ppmp6_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept && has_result),
        .i_result    (core_result),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_kind         = out_result.kind;
    assign o_address      = out_result.address;
    assign o_pixel_byte   = out_result.pixel_byte;
    assign o_image_width  = out_result.image_width;
    assign o_image_height = out_result.image_height;
    assign o_row_stride   = out_result.row_stride;
    assign o_error_code   = out_result.error_code;
    assign o_image_done   = out_result.image_done;

endmodule

// ===== tb/tb.sv =====
module tb;
    import ppmp6_pkg::*;

    // Run length and safety limits. The random part stops once this many bytes that the
    // parser actually acts on have been accepted; the cycle limit is far above the slowest
    // legal run (every byte waiting out a full sender gap and a full receiver stall).
    localparam int RANDOM_ITEMS = 1050;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;

    // How a directed row is checked: by the predictor, against a result typed into the
    // table, or as a byte that must produce nothing.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_GIVEN,
        CHK_NONE
    } t_chk;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
        t_chk       chk;
        t_result    want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic [7:0]            i_data_byte    = 8'h00;
    logic                  i_end_of_input = 1'b0;
    logic                  i_out_stall    = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [1:0]            o_kind;
    logic [ADDR_W-1:0]     o_address;
    logic [7:0]            o_pixel_byte;
    logic [IMG_W-1:0]      o_image_width;
    logic [IMG_W-1:0]      o_image_height;
    logic [STRIDE_W-1:0]   o_row_stride;
    logic [2:0]            o_error_code;
    logic                  o_image_done;

    ppm_p6_stream_decoder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_address      (o_address),
        .o_pixel_byte   (o_pixel_byte),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_row_stride   (o_row_stride),
        .o_error_code   (o_error_code),
        .o_image_done   (o_image_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results the decoder still owes, oldest first, and the run's bookkeeping.
    t_result    due_results[$];
    t_row       directed_rows[$];
    logic [8:0] file_bytes[$];
    int         fail_count   = 0;
    int         live_items   = 0;
    int         cycle_count  = 0;
    bit         send_idle_on = 1'b1;
    bit         recv_idle_on = 1'b1;
    bit         long_hold_req = 1'b0;

    // Shadow copy of the parser state, advanced once per accepted input transaction.
    t_phase      dec_phase;
    logic [1:0]  dec_field;
    logic [16:0] dec_acc;
    logic        dec_ovf;
    logic        dec_comment;
    logic [12:0] dec_width;
    logic [12:0] dec_height;
    logic [13:0] dec_stride;
    logic [25:0] dec_row_base;
    logic [12:0] dec_col;
    logic [1:0]  dec_comp;
    logic [12:0] dec_row;

    function automatic void clear_decoder();
        dec_phase    = PH_MAGIC;
        dec_field    = '0;
        dec_acc      = '0;
        dec_ovf      = 1'b0;
        dec_comment  = 1'b0;
        dec_width    = '0;
        dec_height   = '0;
        dec_stride   = '0;
        dec_row_base = '0;
        dec_col      = '0;
        dec_comp     = '0;
        dec_row      = '0;
    endfunction

    function automatic t_result err_result(input t_err code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic t_result hdr_result(input logic [12:0] w, input logic [12:0] h,
                                           input logic [13:0] s);
        t_result r;
        r              = '0;
        r.kind         = KIND_HEADER;
        r.image_width  = w;
        r.image_height = h;
        r.row_stride   = s;
        return r;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    // Advances the shadow parser by one byte. Returns 1 and fills r when the byte
    // produces a result.
    function automatic bit decode_byte(input logic [7:0] b, input logic eoi,
                                       output t_result r);
        t_phase      was;
        logic [31:0] v;
        logic [31:0] s;
        int unsigned lim;
        logic [25:0] a;
        bit          has;
        bit          bad;
        t_err        code;
        r    = '0;
        has  = 1'b0;
        bad  = 1'b0;
        code = ERR_NO_MAGIC;
        if (eoi) begin
            // End of input always resets; it reports unless an image had finished or failed.
            was = dec_phase;
            clear_decoder();
            if (was == PH_MAGIC) begin
                r   = err_result(ERR_NO_MAGIC);
                has = 1'b1;
            end else if (was != PH_DONE && was != PH_ERROR) begin
                r   = err_result(ERR_TRUNCATED);
                has = 1'b1;
            end
            return has;
        end
        case (dec_phase)
            PH_MAGIC: begin
                if (b != CH_P) begin
                    bad = 1'b1;
                end else begin
                    dec_phase = PH_SUBTYPE;
                end
            end
            PH_SUBTYPE: begin
                if (b == CH_2 || b == CH_3 || b == CH_5) begin
                    bad  = 1'b1;
                    code = ERR_UNSUPPORTED;
                end else if (b != CH_6) begin
                    bad = 1'b1;
                end else begin
                    dec_field   = '0;
                    dec_comment = 1'b0;
                    dec_phase   = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (dec_comment) begin
                    if (b == CH_LF) dec_comment = 1'b0;
                end else if (is_blank(b)) begin
                end else if (b == CH_HASH) begin
                    dec_comment = 1'b1;
                end else if (!is_digit(b)) begin
                    bad  = 1'b1;
                    code = ERR_BAD_VALUE;
                end else begin
                    dec_acc   = 17'(b - CH_0);
                    dec_ovf   = 1'b0;
                    dec_phase = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (is_digit(b)) begin
                    v = 32'(dec_acc) * 32'd10 + 32'(b - CH_0);
                    if (v > 32'h1FFFF) dec_ovf = 1'b1;
                    dec_acc = v[16:0];
                end else begin
                    // The terminator is swallowed; a hash opens a comment.
                    if (b == CH_HASH) dec_comment = 1'b1;
                    v = 32'(dec_acc);
                    if (dec_field != 2'd2) begin
                        lim = (dec_field == 2'd0) ? DEFAULT_MAX_WIDTH : DEFAULT_MAX_HEIGHT;
                        if (!dec_ovf && v == 0) begin
                            bad  = 1'b1;
                            code = ERR_BAD_VALUE;
                        end else if (dec_ovf || v > lim) begin
                            bad  = 1'b1;
                            code = ERR_TOO_LARGE;
                        end else begin
                            if (dec_field == 2'd0) dec_width = v[12:0];
                            else dec_height = v[12:0];
                            dec_field = dec_field + 2'd1;
                            dec_phase = PH_SKIP;
                        end
                    end else if (v[15:0] == 16'h0000) begin
                        bad  = 1'b1;
                        code = ERR_BAD_VALUE;
                    end else begin
                        s            = (32'(dec_width) * 32'd3 + 32'd3) & 32'hFFFF_FFFC;
                        dec_stride   = s[13:0];
                        s            = (32'(dec_height) - 32'd1) * 32'(dec_stride);
                        dec_row_base = s[25:0];
                        dec_col      = '0;
                        dec_comp     = '0;
                        dec_row      = '0;
                        dec_phase    = PH_PIXELS;
                        r   = hdr_result(dec_width, dec_height, dec_stride);
                        has = 1'b1;
                    end
                end
            end
            PH_PIXELS: begin
                if (dec_comment) begin
                    if (b == CH_LF) dec_comment = 1'b0;
                end else begin
                    // Components arrive R,G,B and land in B,G,R order.
                    a = dec_row_base + 26'(dec_col) * 26'd3 + 26'(2'd2 - dec_comp);
                    r.kind       = KIND_PIXEL;
                    r.address    = a;
                    r.pixel_byte = b;
                    has = 1'b1;
                    if (dec_comp < 2'd2) begin
                        dec_comp = dec_comp + 2'd1;
                    end else begin
                        dec_comp = '0;
                        dec_col  = dec_col + 13'd1;
                        if (dec_col >= dec_width) begin
                            dec_col      = '0;
                            dec_row      = dec_row + 13'd1;
                            dec_row_base = dec_row_base - 26'(dec_stride);
                            if (dec_row >= dec_height) begin
                                dec_phase    = PH_DONE;
                                r.image_done = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (bad) begin
            r         = err_result(code);
            dec_phase = PH_ERROR;
            has       = 1'b1;
        end
        return has;
    endfunction

    // Offers one input transaction, holds it until the decoder takes it, and books the
    // result it is due to produce.
    task automatic send_item(input logic [7:0] b, input logic eoi, input t_chk chk,
                             input t_result want);
        int      gap;
        t_result got;
        bit      has;
        bit      ignored;
        gap = 0;
        if (send_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_in_stall);
        ignored = !eoi && (dec_phase == PH_DONE || dec_phase == PH_ERROR);
        if (!ignored) live_items++;
        has = decode_byte(b, eoi, got);
        case (chk)
            CHK_MODEL: if (has) due_results.push_back(got);
            CHK_GIVEN: due_results.push_back(want);
            default: begin
            end
        endcase
    endtask

    // Stops offering bytes until every booked result has come back, then lets the
    // pipeline settle. It always waits for a clock edge before it checks, so that
    // the valid line never gets two updates in one step.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [7:0] b, input logic eoi, input t_chk chk,
                           input t_result want);
        t_row row;
        row.data = b;
        row.eoi  = eoi;
        row.chk  = chk;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic add_byte(input logic [7:0] b);
        file_bytes.push_back({1'b0, b});
    endtask

    // A comment runs from a hash through the next line feed.
    task automatic add_comment();
        logic [7:0] c;
        add_byte(CH_HASH);
        repeat ($urandom_range(0, 4)) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
            add_byte(c);
        end
        add_byte(CH_LF);
    endtask

    task automatic add_blank();
        case ($urandom_range(0, 3))
            0: add_byte(CH_SPACE);
            1: add_byte(CH_TAB);
            2: add_byte(CH_LF);
            default: add_byte(CH_CR);
        endcase
    endtask

    task automatic add_spacing();
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 2) == 0) add_comment();
            else add_blank();
        end
    endtask

    task automatic add_number(input int v);
        string digits;
        int    k;
        digits = $sformatf("%0d", v);
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) add_byte(CH_0);
        for (k = 0; k < digits.len(); k++) add_byte(digits[k]);
    endtask

    // Ends a number: a blank, a comment, or any other single non-digit byte.
    task automatic add_terminator();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0: add_blank();
            1: add_comment();
            default: begin
                do c = 8'($urandom_range(0, 255)); while (is_digit(c) || c == CH_HASH);
                add_byte(c);
            end
        endcase
    endtask

    // Builds one whole file, ending in end of input. Most files have a good header with
    // random spacing, comments and pixel data; the rest break the header in one way.
    task automatic build_file(input bit force_good);
        int         vals[3];
        int         shape;
        int         bad_field;
        int         n;
        int         f;
        bit         broken;
        bit         big;
        bit         stop;
        logic [7:0] c;
        file_bytes.delete();
        broken    = !force_good && ($urandom_range(0, 9) < 3);
        shape     = broken ? $urandom_range(0, 7) : 0;
        bad_field = $urandom_range(0, 1);
        big       = 1'b0;
        if (force_good) begin
            vals[0] = 4;
            vals[1] = 3;
        end else if ($urandom_range(0, 15) == 0) begin
            // Largest sizes only ever get a few pixel bytes before the file is cut.
            big     = 1'b1;
            vals[0] = $urandom_range(0, 1) ? DEFAULT_MAX_WIDTH
                                           : $urandom_range(1, DEFAULT_MAX_WIDTH);
            vals[1] = $urandom_range(0, 1) ? DEFAULT_MAX_HEIGHT
                                           : $urandom_range(1, DEFAULT_MAX_HEIGHT);
        end else begin
            vals[0] = $urandom_range(1, 6);
            vals[1] = $urandom_range(1, 4);
        end
        case ($urandom_range(0, 3))
            0, 1: vals[2] = 255;
            2: vals[2] = $urandom_range(1, 65535);
            // Past 16 bits: only the low 16 bits of the accumulator count.
            default: vals[2] = 65536 * $urandom_range(1, 10) + $urandom_range(1, 65535);
        endcase
        if (broken) begin
            case (shape)
                3: vals[bad_field] = 0;
                4: vals[bad_field] = $urandom_range(0, 1)
                                   ? DEFAULT_MAX_WIDTH + 1 + $urandom_range(0, 5000)
                                   : $urandom_range(131072, 99999999);
                5: vals[2] = 65536 * $urandom_range(0, 20);
                default: begin
                end
            endcase
            if (shape == 2 || shape == 6) bad_field = $urandom_range(0, 2);
        end
        if (broken && shape == 0) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_P);
            add_byte(c);
        end else if (broken && shape == 1) begin
            add_byte(CH_P);
            case ($urandom_range(0, 3))
                0: add_byte(CH_2);
                1: add_byte(CH_3);
                2: add_byte(CH_5);
                default: begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_6);
                    add_byte(c);
                end
            endcase
        end else if (broken && shape == 7) begin
            repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            add_byte(CH_P);
            add_byte(CH_6);
            stop = 1'b0;
            for (f = 0; f < 3 && !stop; f++) begin
                add_spacing();
                if (broken && shape == 2 && f == bad_field) begin
                    do c = 8'($urandom_range(0, 255));
                    while (is_digit(c) || is_blank(c) || c == CH_HASH);
                    add_byte(c);
                    stop = 1'b1;
                end else if (broken && shape == 6 && f == bad_field) begin
                    stop = 1'b1;
                end else begin
                    add_number(vals[f]);
                    add_terminator();
                end
            end
            if (!broken) begin
                n = vals[0] * vals[1] * 3;
                if (big) n = $urandom_range(0, 12);
                else if (!force_good && $urandom_range(0, 3) == 0) n = $urandom_range(0, n - 1);
                repeat (n) add_byte(8'($urandom_range(0, 255)));
            end
        end
        // Trailing bytes: ignored after an error or a finished image, parsed as more input otherwise.
        if (!force_good) repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
        file_bytes.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: every transaction the decoder hands over is matched against the
    // oldest result still owed.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $error("result with nothing owed: kind %0d", o_kind);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                check_field("kind",         32'(want.kind),         32'(o_kind));
                check_field("address",      32'(want.address),      32'(o_address));
                check_field("pixel_byte",   32'(want.pixel_byte),   32'(o_pixel_byte));
                check_field("image_width",  32'(want.image_width),  32'(o_image_width));
                check_field("image_height", 32'(want.image_height), 32'(o_image_height));
                check_field("row_stride",   32'(want.row_stride),   32'(o_row_stride));
                check_field("error_code",   32'(want.error_code),   32'(o_error_code));
                check_field("image_done",   32'(want.image_done),   32'(o_image_done));
            end
        end
    end

    // Receiver back-pressure. Normally it switches at random between free runs and stall
    // bursts; on request it holds off for a long stretch so that the result buffer
    // fills and the decoder has to stall its input.
    int stall_left = 0;
    int hold_left  = 0;
    bit stalling   = 1'b0;

    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!recv_idle_on) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stalling   = ($urandom_range(0, 2) == 0);
                stall_left = stalling ? $urandom_range(1, 14) : $urandom_range(1, 24);
            end
            stall_left--;
            i_out_stall <= stalling;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int file_no;
        clear_decoder();

        // Directed part. End of input straight after reset, a bad first byte, an
        // unsupported variant, a header cut short, and a 1x1 image whose header is
        // wrapped in comments and space/tab blanks, ending with a byte after the last pixel.
        add_row(8'h00, 1'b1, CHK_GIVEN, err_result(ERR_NO_MAGIC));
        add_row(8'hFF, 1'b0, CHK_GIVEN, err_result(ERR_NO_MAGIC));
        add_row(8'h00, 1'b1, CHK_NONE, '0);
        add_row(CH_P,  1'b0, CHK_NONE, '0);
        add_row(CH_2,  1'b0, CHK_GIVEN, err_result(ERR_UNSUPPORTED));
        add_row(8'hFF, 1'b1, CHK_NONE, '0);
        add_row(CH_P,  1'b0, CHK_NONE, '0);
        add_row(CH_6,  1'b0, CHK_NONE, '0);
        add_row(8'h00, 1'b1, CHK_GIVEN, err_result(ERR_TRUNCATED));
        add_row(CH_P,  1'b0, CHK_NONE, '0);
        add_row(CH_6,  1'b0, CHK_NONE, '0);
        add_row(CH_HASH, 1'b0, CHK_NONE, '0);
        add_row(8'hFF, 1'b0, CHK_NONE, '0);
        add_row(CH_LF, 1'b0, CHK_NONE, '0);
        add_row(CH_0 + 8'd1, 1'b0, CHK_NONE, '0);
        add_row(CH_SPACE, 1'b0, CHK_NONE, '0);
        add_row(CH_0 + 8'd1, 1'b0, CHK_NONE, '0);
        add_row(CH_TAB, 1'b0, CHK_NONE, '0);
        add_row(CH_0 + 8'd1, 1'b0, CHK_NONE, '0);
        // A hash after maxval ends the header and opens a comment over the pixel data.
        add_row(CH_HASH, 1'b0, CHK_GIVEN, hdr_result(13'd1, 13'd1, 14'd4));
        add_row(CH_CR, 1'b0, CHK_NONE, '0);
        add_row(CH_LF, 1'b0, CHK_NONE, '0);
        add_row(8'h00, 1'b0, CHK_MODEL, '0);
        add_row(8'hFF, 1'b0, CHK_MODEL, '0);
        add_row(8'h5A, 1'b0, CHK_MODEL, '0);
        add_row(8'h41, 1'b0, CHK_NONE, '0);
        add_row(8'h00, 1'b1, CHK_NONE, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_item(directed_rows[k].data, directed_rows[k].eoi, directed_rows[k].chk,
                      directed_rows[k].want);
        wait_drained();

        // Random part: whole files, mostly well formed. One early file runs against a
        // long receiver hold with the sender offering bytes back to back, and the sender
        // pauses for a full drain after it and now and then between files. The last
        // stretch runs with no idling at all.
        file_no = 0;
        while (live_items < directed_rows.size() + RANDOM_ITEMS) begin
            if (live_items > directed_rows.size() + RANDOM_ITEMS - QUIET_TAIL) begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end else begin
                send_idle_on = ($urandom_range(0, 4) != 0);
            end
            if (file_no == 4) begin
                send_idle_on  = 1'b0;
                long_hold_req = 1'b1;
                build_file(1'b1);
            end else begin
                build_file(1'b0);
            end
            foreach (file_bytes[k])
                send_item(file_bytes[k][7:0], file_bytes[k][8], CHK_MODEL, '0);
            if (file_no == 4 || (recv_idle_on && $urandom_range(0, 3) == 0)) wait_drained();
            file_no++;
        end

        wait_drained();
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
